/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication violated");

// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

/* rtl/nsc_pkg.sv */
// ----------------------------------------------------------------------------
// nsc_pkg
// types, character codes and digit decode for the sentence checker
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_Z      = 8'h7A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam int unsigned FIELD_W  = 6;
  localparam logic [FIELD_W-1:0] SEP_COUNT_MAX = '1;
  localparam logic [2:0] BYTE_COUNT_MAX = 3'd7;
  localparam logic [2:0] MIN_LENGTH     = 3'd6;
  localparam int unsigned TAIL_DEPTH    = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_DATA     = 2'd2,
    ST_CHECKSUM = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]         byte_out;
    logic [FIELD_W-1:0] field_index;
    logic               is_separator;
    logic               sentence_done;
    status_t            status;
    logic [FIELD_W-1:0] separator_count;
    logic [7:0]         checksum_computed;
  } result_t;

  // hex digit decode, letters from 'A' up, anything else relative to '0'
  function automatic logic signed [8:0] digit_value(input logic [7:0] c);
    logic signed [8:0] v;
    v = $signed({1'b0, c});
    if (c >= CH_A) begin
      digit_value = v - $signed({1'b0, CH_A}) + 9'sd10;
    end else begin
      digit_value = v - $signed({1'b0, CH_ZERO});
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/nsc_in_stage.sv */
// ----------------------------------------------------------------------------
// nsc_in_stage
// input register for one sentence byte and its last mark
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire logic [7:0] up_byte,
  input  wire logic       up_last,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output logic [7:0]      dn_byte,
  output logic            dn_last
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      byte_r <= up_byte;
      last_r <= up_last;
    end
  end

  assign dn_valid = valid_r;
  assign dn_byte  = byte_r;
  assign dn_last  = last_r;

endmodule

`default_nettype wire

/* rtl/nsc_tracker.sv */
// ----------------------------------------------------------------------------
// nsc_tracker
// per-sentence state and the result for the byte being retired
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_tracker #(
  parameter int unsigned FIELD_INDEX_MAX = 63
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] byte_in,
  input  wire logic       last_byte,
  output nsc_pkg::result_t res
);

  localparam int unsigned FIELD_LIMIT_I =
    (FIELD_INDEX_MAX > 63) ? 63 : FIELD_INDEX_MAX;
  localparam logic [nsc_pkg::FIELD_W-1:0] FIELD_LIMIT =
    FIELD_LIMIT_I[nsc_pkg::FIELD_W-1:0];
  localparam logic [nsc_pkg::FIELD_W-1:0] FIELD_ONE =
    {{(nsc_pkg::FIELD_W-1){1'b0}}, 1'b1};

  logic [7:0]                  tail_r   [nsc_pkg::TAIL_DEPTH];
  logic [7:0]                  tail_nxt [nsc_pkg::TAIL_DEPTH];
  logic [7:0]                  xor_r, xor_nxt;
  logic [2:0]                  cnt_r, cnt_nxt;
  logic                        start_r, start_nxt;
  logic                        bad_r, bad_nxt;
  logic [nsc_pkg::FIELD_W-1:0] field_r, field_nxt;
  logic [nsc_pkg::FIELD_W-1:0] sepc_r, sepc_nxt;

  logic               sep;
  logic               len_ok;
  logic               fmt_ok;
  logic [7:0]         csum;
  logic signed [12:0] given;
  logic signed [12:0] csum_s;

  always_comb begin
    sep       = (byte_in == nsc_pkg::CH_COMMA) || (byte_in == nsc_pkg::CH_STAR);
    start_nxt = (cnt_r == 3'd0) ? (byte_in == nsc_pkg::CH_DOLLAR) : start_r;
    xor_nxt   = (cnt_r == 3'd0) ? xor_r : (xor_r ^ byte_in);
    cnt_nxt   = (cnt_r < nsc_pkg::BYTE_COUNT_MAX) ? cnt_r + 3'd1 : cnt_r;
    bad_nxt   = bad_r || (byte_in > nsc_pkg::CH_Z) || (byte_in < nsc_pkg::CH_LF);
    for (int i = 0; i < nsc_pkg::TAIL_DEPTH - 1; i++) begin
      tail_nxt[i] = tail_r[i+1];
    end
    tail_nxt[nsc_pkg::TAIL_DEPTH-1] = byte_in;
    field_nxt = (sep && (field_r < FIELD_LIMIT)) ? field_r + FIELD_ONE : field_r;
    sepc_nxt  = (sep && (sepc_r != nsc_pkg::SEP_COUNT_MAX)) ? sepc_r + FIELD_ONE : sepc_r;
  end

  // result for the current byte, with checksum and status on the closing byte
  always_comb begin
    len_ok = (cnt_nxt >= nsc_pkg::MIN_LENGTH);
    csum   = len_ok ? (xor_nxt ^ tail_nxt[0] ^ tail_nxt[1] ^ tail_nxt[2] ^
                       tail_nxt[3] ^ tail_nxt[4]) : 8'h00;
    fmt_ok = start_nxt && len_ok && (tail_nxt[0] == nsc_pkg::CH_STAR) &&
             (tail_nxt[3] == nsc_pkg::CH_CR) && (tail_nxt[4] == nsc_pkg::CH_LF);
    given  = (13'(nsc_pkg::digit_value(tail_nxt[1])) <<< 4) +
             13'(nsc_pkg::digit_value(tail_nxt[2]));
    csum_s = $signed({5'b0, csum});

    res.byte_out          = byte_in;
    res.field_index       = field_r;
    res.is_separator      = sep;
    res.sentence_done     = last_byte;
    res.status            = nsc_pkg::ST_OK;
    res.separator_count   = '0;
    res.checksum_computed = '0;
    if (last_byte) begin
      res.separator_count   = sepc_nxt;
      res.checksum_computed = csum;
      if (!fmt_ok) begin
        res.status = nsc_pkg::ST_FORMAT;
      end else if (bad_nxt) begin
        res.status = nsc_pkg::ST_DATA;
      end else if (given != csum_s) begin
        res.status = nsc_pkg::ST_CHECKSUM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      for (int i = 0; i < nsc_pkg::TAIL_DEPTH; i++) begin
        tail_r[i] <= 8'h00;
      end
      xor_r   <= 8'h00;
      cnt_r   <= 3'd0;
      start_r <= 1'b0;
      bad_r   <= 1'b0;
      field_r <= '0;
      sepc_r  <= '0;
    end else if (step) begin
      for (int i = 0; i < nsc_pkg::TAIL_DEPTH; i++) begin
        tail_r[i] <= tail_nxt[i];
      end
      xor_r   <= xor_nxt;
      cnt_r   <= cnt_nxt;
      start_r <= start_nxt;
      bad_r   <= bad_nxt;
      field_r <= field_nxt;
      sepc_r  <= sepc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/nsc_out_stage.sv */
// ----------------------------------------------------------------------------
// nsc_out_stage
// result register toward the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire nsc_pkg::result_t up_res,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output nsc_pkg::result_t      dn_res
);

  logic             valid_r;
  logic             valid_nxt;
  nsc_pkg::result_t res_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      res_r <= up_res;
    end
  end

  assign dn_valid = valid_r;
  assign dn_res   = res_r;

endmodule

`default_nettype wire

/* rtl/nmea_sentence_checker_top.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_checker_top
// byte-stream checker for dollar-framed, star-checksummed sentences
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carry one sentence byte per transaction,
//   with in_last_byte high on the closing byte; the next byte opens a new one
//   output channel: out_valid/out_ready carry one result per input byte: the
//   byte, its field index, the separator flag and, on the closing byte, the
//   status, separator count and computed xor checksum
//   path: each result passes through the input register, then the result
//   register; the sentence state is updated when a byte moves from the input
//   register into the result register
//   throughput: one byte per cycle while out_ready stays high, with the state
//   update (xor, compares, five-byte tail shift register) in combinational logic
//   stall: when out_ready is low the result register holds and the input
//   register can still take one more transaction before in_ready drops
//   reset: rst_n low clears both valid flags and all sentence state; the first
//   byte after reset starts a sentence
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nmea_sentence_checker_top #(
  parameter int unsigned FIELD_INDEX_MAX = 63
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte_out,
  output logic [5:0]      out_field_index,
  output logic            out_is_separator,
  output logic            out_sentence_done,
  output logic [1:0]      out_status,
  output logic [5:0]      out_separator_count,
  output logic [7:0]      out_checksum_computed
);

  localparam int unsigned FIELD_LIMIT_I =
    (FIELD_INDEX_MAX > 63) ? 63 : FIELD_INDEX_MAX;

  // between input register and result register
  logic             mid_valid;
  logic             mid_ready;
  logic [7:0]       mid_byte;
  logic             mid_last;
  logic             step;
  nsc_pkg::result_t mid_res;
  nsc_pkg::result_t out_res;

  nsc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_byte  (in_byte_in),
    .up_last  (in_last_byte),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_byte  (mid_byte),
    .dn_last  (mid_last)
  );

  // state advances exactly when a byte is handed to the result register
  assign step = mid_valid && mid_ready;

  nsc_tracker #(
    .FIELD_INDEX_MAX (FIELD_INDEX_MAX)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (mid_byte),
    .last_byte (mid_last),
    .res       (mid_res)
  );

  nsc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_res   (mid_res),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_res   (out_res)
  );

  assign out_byte_out          = out_res.byte_out;
  assign out_field_index       = out_res.field_index;
  assign out_is_separator      = out_res.is_separator;
  assign out_sentence_done     = out_res.sentence_done;
  assign out_status            = out_res.status;
  assign out_separator_count   = out_res.separator_count;
  assign out_checksum_computed = out_res.checksum_computed;

  // status fields are zero except on the closing byte
  `ASSERT_IMP(a_status_only_when_done,
    out_valid && !out_sentence_done,
    out_status == nsc_pkg::ST_OK && out_separator_count == '0 &&
    out_checksum_computed == '0)

  // a good sentence always ends on a line feed
  `ASSERT_IMP(a_ok_ends_with_lf,
    out_valid && out_sentence_done && out_status == nsc_pkg::ST_OK,
    out_byte_out == nsc_pkg::CH_LF)

  // field index never passes its limit
  `ASSERT_IMP(a_field_index_limit,
    out_valid, 32'(out_field_index) <= FIELD_LIMIT_I)

  // a byte waiting behind a stalled result stays in the input register
  `ASSERT_NXT(a_mid_holds_on_stall,
    mid_valid && !mid_ready, mid_valid && $stable(mid_byte) && $stable(mid_last))

endmodule

`default_nettype wire
